// File: rtl/nrs_pkg.sv
// ============================================================================
// nrs_pkg
// Shared types and codes for the navigation recovery supervisor.
// ============================================================================
package nrs_pkg;

    localparam int CNT_W = 16;

    typedef logic [CNT_W-1:0] cnt_t;

    // modes
    localparam logic [1:0] MODE_PLANNING    = 2'd0;
    localparam logic [1:0] MODE_CONTROLLING = 2'd1;
    localparam logic [1:0] MODE_RECOVERY    = 2'd2;

    // recovery stages
    localparam logic [1:0] STAGE_CONSERVATIVE = 2'd0;
    localparam logic [1:0] STAGE_ROTATE       = 2'd1;
    localparam logic [1:0] STAGE_AGGRESSIVE   = 2'd2;
    localparam logic [1:0] STAGE_ABORT        = 2'd3;

    // run status
    localparam logic [1:0] ST_RUNNING   = 2'd0;
    localparam logic [1:0] ST_SUCCEEDED = 2'd1;
    localparam logic [1:0] ST_ABORTED   = 2'd2;
    localparam logic [1:0] ST_PREEMPTED = 2'd3;

    // velocity actions
    localparam logic [1:0] VEL_NONE    = 2'd0;
    localparam logic [1:0] VEL_COMMAND = 2'd1;
    localparam logic [1:0] VEL_ZERO    = 2'd2;

    // map actions
    localparam logic [2:0] MAP_NONE         = 3'd0;
    localparam logic [2:0] MAP_CLEAR        = 3'd1;
    localparam logic [2:0] MAP_CONSERVATIVE = 3'd2;
    localparam logic [2:0] MAP_ROTATE       = 3'd3;
    localparam logic [2:0] MAP_AGGRESSIVE   = 3'd4;

    // commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // config register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLAN_PATIENCE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_PATIENCE = 2'd1;

    localparam cnt_t PLAN_PATIENCE_RST    = 16'd100;
    localparam cnt_t CONTROL_PATIENCE_RST = 16'd300;

    typedef struct packed {
        logic command;
        logic preempt;
        logic sensors_current;
        logic plan_found;
        logic plan_accepted;
        logic goal_reached;
        logic control_found;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] velocity_action;
        logic [2:0] map_action;
        logic [1:0] mode_now;
        logic [1:0] stage_now;
    } result_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] stage;
        cnt_t       ticks_since_plan;
        cnt_t       ticks_since_control;
    } sup_state_t;

    typedef struct packed {
        cnt_t plan_patience;
        cnt_t control_patience;
    } patience_t;

endpackage

// File: rtl/nrs_step.sv
// ============================================================================
// nrs_step
// One supervisor pass: next state and result word for one item.
// ============================================================================
module nrs_step (
    input  nrs_pkg::item_t      item,
    input  nrs_pkg::sup_state_t cur,
    input  nrs_pkg::patience_t  patience,
    output nrs_pkg::sup_state_t nxt,
    output nrs_pkg::result_t    result
);

    nrs_pkg::cnt_t plan_inc;
    nrs_pkg::cnt_t ctrl_inc;
    logic [1:0]    status;
    logic [1:0]    vel;
    logic [2:0]    map;

    assign plan_inc = (cur.ticks_since_plan == '1) ? cur.ticks_since_plan
                                                   : cur.ticks_since_plan + 1'b1;
    assign ctrl_inc = (cur.ticks_since_control == '1) ? cur.ticks_since_control
                                                      : cur.ticks_since_control + 1'b1;

    always_comb
    begin
        nxt    = cur;
        status = nrs_pkg::ST_RUNNING;
        vel    = nrs_pkg::VEL_NONE;
        map    = nrs_pkg::MAP_NONE;

        if (item.command == nrs_pkg::CMD_START)
        begin
            nxt.ticks_since_plan    = '0;
            nxt.ticks_since_control = '0;
            map                     = nrs_pkg::MAP_CLEAR;
        end
        else if (item.preempt)
        begin
            nxt.mode  = nrs_pkg::MODE_PLANNING;
            nxt.stage = nrs_pkg::STAGE_CONSERVATIVE;
            status    = nrs_pkg::ST_PREEMPTED;
            vel       = nrs_pkg::VEL_ZERO;
        end
        else
        begin
            nxt.ticks_since_plan    = plan_inc;
            nxt.ticks_since_control = ctrl_inc;
            if (!item.sensors_current)
            begin
                vel = nrs_pkg::VEL_ZERO;
            end
            else
            begin
                case (cur.mode)
                    nrs_pkg::MODE_PLANNING:
                    begin
                        if (item.plan_found)
                        begin
                            vel = nrs_pkg::VEL_ZERO;
                            if (!item.plan_accepted)
                            begin
                                nxt.mode  = nrs_pkg::MODE_PLANNING;
                                nxt.stage = nrs_pkg::STAGE_CONSERVATIVE;
                                status    = nrs_pkg::ST_ABORTED;
                            end
                            else
                            begin
                                nxt.ticks_since_plan = '0;
                                nxt.mode             = nrs_pkg::MODE_CONTROLLING;
                                nxt.stage            = nrs_pkg::STAGE_CONSERVATIVE;
                            end
                        end
                        else if (plan_inc > patience.plan_patience)
                        begin
                            nxt.mode = nrs_pkg::MODE_RECOVERY;
                            vel      = nrs_pkg::VEL_ZERO;
                        end
                    end
                    nrs_pkg::MODE_CONTROLLING:
                    begin
                        if (item.goal_reached)
                        begin
                            nxt.mode  = nrs_pkg::MODE_PLANNING;
                            nxt.stage = nrs_pkg::STAGE_CONSERVATIVE;
                            status    = nrs_pkg::ST_SUCCEEDED;
                            vel       = nrs_pkg::VEL_ZERO;
                        end
                        else if (item.control_found)
                        begin
                            nxt.ticks_since_control = '0;
                            vel                     = nrs_pkg::VEL_COMMAND;
                        end
                        else if (ctrl_inc > patience.control_patience)
                        begin
                            nxt.mode  = nrs_pkg::MODE_PLANNING;
                            nxt.stage = nrs_pkg::STAGE_CONSERVATIVE;
                            status    = nrs_pkg::ST_ABORTED;
                            vel       = nrs_pkg::VEL_ZERO;
                        end
                        else
                        begin
                            // lost the command: back to planning
                            nxt.ticks_since_plan = '0;
                            nxt.mode             = nrs_pkg::MODE_PLANNING;
                            vel                  = nrs_pkg::VEL_ZERO;
                        end
                    end
                    nrs_pkg::MODE_RECOVERY:
                    begin
                        case (cur.stage)
                            nrs_pkg::STAGE_CONSERVATIVE:
                            begin
                                map       = nrs_pkg::MAP_CONSERVATIVE;
                                nxt.stage = nrs_pkg::STAGE_ROTATE;
                                nxt.mode  = nrs_pkg::MODE_PLANNING;
                            end
                            nrs_pkg::STAGE_ROTATE:
                            begin
                                map       = nrs_pkg::MAP_ROTATE;
                                nxt.stage = nrs_pkg::STAGE_AGGRESSIVE;
                                nxt.mode  = nrs_pkg::MODE_PLANNING;
                            end
                            nrs_pkg::STAGE_AGGRESSIVE:
                            begin
                                map       = nrs_pkg::MAP_AGGRESSIVE;
                                nxt.stage = nrs_pkg::STAGE_ABORT;
                                nxt.mode  = nrs_pkg::MODE_PLANNING;
                            end
                            default:
                            begin
                                nxt.mode  = nrs_pkg::MODE_PLANNING;
                                nxt.stage = nrs_pkg::STAGE_CONSERVATIVE;
                                status    = nrs_pkg::ST_ABORTED;
                                vel       = nrs_pkg::VEL_ZERO;
                            end
                        endcase
                    end
                    default:
                    begin
                        nxt.mode  = nrs_pkg::MODE_PLANNING;
                        nxt.stage = nrs_pkg::STAGE_CONSERVATIVE;
                        status    = nrs_pkg::ST_ABORTED;
                        vel       = nrs_pkg::VEL_ZERO;
                    end
                endcase
            end
        end
    end

    assign result.status          = status;
    assign result.velocity_action = vel;
    assign result.map_action      = map;
    assign result.mode_now        = nxt.mode;
    assign result.stage_now       = nxt.stage;

endmodule

// File: rtl/navigation_recovery_supervisor_top.sv
// ============================================================================
// navigation_recovery_supervisor_top
// Tick-driven navigation supervisor: planning / controlling / recovery modes
// with escalating recovery and saturating patience counters.
// ============================================================================
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------
//  item      item_valid/stall     item_word   (nrs_pkg::item_t)
//  result    result_valid/stall   result_word (nrs_pkg::result_t)
//  cfg       cfg_valid/ready      cfg_index, cfg_data
//
//  One word per cycle sustained while result_stall is low. A word is
//  registered on input, evaluated in one pass of nrs_step and lands in the
//  result register, where it is offered on result_valid. Supervisor state
//  updates as the word moves to the result register. Stall on result backs up
//  into the input register and then onto item_stall. Reset clears state and
//  both valid flags and restores the patience registers to their defaults.
//
module navigation_recovery_supervisor_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  nrs_pkg::item_t                      item_word,
    output logic                                result_valid,
    input  logic                                result_stall,
    output nrs_pkg::result_t                    result_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [nrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  nrs_pkg::cnt_t                       cfg_data
);

    logic                in_valid_reg;
    nrs_pkg::item_t      in_word_reg;
    logic                out_valid_reg;
    nrs_pkg::result_t    out_word_reg;
    nrs_pkg::sup_state_t state_reg;
    nrs_pkg::sup_state_t state_next;
    nrs_pkg::patience_t  patience_reg;
    nrs_pkg::result_t    step_result;
    logic                advance;
    logic                take_in;

    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign take_in    = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    nrs_step u_step (
        .item     (in_word_reg),
        .cur      (state_reg),
        .patience (patience_reg),
        .nxt      (state_next),
        .result   (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode: nrs_pkg::MODE_PLANNING,
                               stage: nrs_pkg::STAGE_CONSERVATIVE,
                               ticks_since_plan: '0,
                               ticks_since_control: '0};
            patience_reg  <= '{plan_patience: nrs_pkg::PLAN_PATIENCE_RST,
                               control_patience: nrs_pkg::CONTROL_PATIENCE_RST};
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == nrs_pkg::CFG_PLAN_PATIENCE)
                    patience_reg.plan_patience <= cfg_data;
                else if (cfg_index == nrs_pkg::CFG_CONTROL_PATIENCE)
                    patience_reg.control_patience <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
            in_word_reg <= item_word;
        if (advance)
            out_word_reg <= step_result;
    end

    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

endmodule
